FILE: rtl/core/ifbs_pkg.sv
`timescale 1ns / 1ps

package ifbs_pkg;

  localparam int unsigned CFG_ADDR_W = 5;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [2:0] {
    REG_FLAG_BYTE        = 3'd0,
    REG_ADDRESS_BYTE     = 3'd1,
    REG_ESCAPE_BYTE      = 3'd2,
    REG_FLAG_ESCAPED     = 3'd3,
    REG_ESCAPE_ESCAPED   = 3'd4,
    REG_CONTROL_SEQ_ZERO = 3'd5,
    REG_CONTROL_SEQ_ONE  = 3'd6,
    REG_NONE             = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic       command;
    logic [7:0] payload_byte;
    logic       final_byte;
  } in_word_t;

  typedef struct packed {
    logic [7:0] line_byte;
    logic       frame_end;
    logic       run_last;
  } out_word_t;

  typedef struct packed {
    logic [7:0] flag_byte;
    logic [7:0] address_byte;
    logic [7:0] escape_byte;
    logic [7:0] flag_escaped;
    logic [7:0] escape_escaped;
    logic [7:0] control_seq_zero;
    logic [7:0] control_seq_one;
  } cfg_t;

  // One queued payload byte with everything the back end needs to send it.
  typedef struct packed {
    logic       header;
    logic       seq;
    logic [7:0] data;
    logic       last;
    logic [7:0] check;
  } job_t;

endpackage

FILE: rtl/core/info_frame_byte_stuffer_core.sv
`timescale 1ns / 1ps

// Transmit framer for a byte-stuffed, HDLC-like link. Each input word is a payload byte or an
// advance-sequence command; the block sends one line byte per cycle from its output register
// while out_stall is low. A stuffed byte goes out as the escape byte and its escaped form; the
// first byte of a frame follows the flag, address, control and BCC1 header bytes and the last
// is followed by the check byte and closing flag. The output sequencer is the only pacing
// element: input words are taken every cycle while the queue of QUEUE_DEPTH entries has room,
// commands take effect at once and give no output, and a word's first line byte passes a queue
// slot and the output register. Registers sit at byte addresses 4*i and read back their values.

module info_frame_byte_stuffer_core
  import ifbs_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_word_t             out_word,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  cfg_t     cfg_r;
  reg_idx_t reg_idx;
  logic     cfg_wr;
  logic     in_accept, q_push, q_pop, q_empty, q_full;
  job_t     push_job, head_job;
  logic [7:0] rd_byte;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.flag_byte        <= 8'h7E;
      cfg_r.address_byte     <= 8'h03;
      cfg_r.escape_byte      <= 8'h7D;
      cfg_r.flag_escaped     <= 8'h5E;
      cfg_r.escape_escaped   <= 8'h5D;
      cfg_r.control_seq_zero <= 8'h00;
      cfg_r.control_seq_one  <= 8'h40;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_FLAG_BYTE:        cfg_r.flag_byte        <= pwdata[7:0];
        REG_ADDRESS_BYTE:     cfg_r.address_byte     <= pwdata[7:0];
        REG_ESCAPE_BYTE:      cfg_r.escape_byte      <= pwdata[7:0];
        REG_FLAG_ESCAPED:     cfg_r.flag_escaped     <= pwdata[7:0];
        REG_ESCAPE_ESCAPED:   cfg_r.escape_escaped   <= pwdata[7:0];
        REG_CONTROL_SEQ_ZERO: cfg_r.control_seq_zero <= pwdata[7:0];
        REG_CONTROL_SEQ_ONE:  cfg_r.control_seq_one  <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_FLAG_BYTE:        rd_byte = cfg_r.flag_byte;
      REG_ADDRESS_BYTE:     rd_byte = cfg_r.address_byte;
      REG_ESCAPE_BYTE:      rd_byte = cfg_r.escape_byte;
      REG_FLAG_ESCAPED:     rd_byte = cfg_r.flag_escaped;
      REG_ESCAPE_ESCAPED:   rd_byte = cfg_r.escape_escaped;
      REG_CONTROL_SEQ_ZERO: rd_byte = cfg_r.control_seq_zero;
      REG_CONTROL_SEQ_ONE:  rd_byte = cfg_r.control_seq_one;
      default:              rd_byte = 8'd0;
    endcase
  end

  assign prdata = {(CFG_DATA_W - 8)'(0), rd_byte};

  assign in_stall  = q_full;
  assign in_accept = in_valid && !in_stall;

  ifbs_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_accept),
    .word   (in_word),
    .push   (q_push),
    .job    (push_job)
  );

  ifbs_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .pop      (q_pop),
    .head_job (head_job),
    .empty    (q_empty),
    .full     (q_full)
  );

  ifbs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .have_job  (!q_empty),
    .job       (head_job),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

`ifndef SYNTHESIS
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.frame_end |-> out_word.run_last)
    else $error("closing flag not marked as last byte of its word");

  a_end_is_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_word.frame_end |-> out_word.line_byte == cfg_r.flag_byte)
    else $error("closing byte differs from the flag byte");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("queue popped while empty");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("queue pushed while full");
`endif

endmodule

FILE: rtl/core/ifbs_front.sv
`timescale 1ns / 1ps

module ifbs_front
  import ifbs_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     accept,
  input  in_word_t word,
  output logic     push,
  output job_t     job
);

  logic       seq_r, seq_nxt;
  logic       inside_r, inside_nxt;
  logic [7:0] check_r, check_nxt;
  logic [7:0] check_sum;

  assign push      = accept && !word.command;
  assign check_sum = (inside_r ? check_r : 8'd0) ^ word.payload_byte;

  always_comb begin
    job.header = !inside_r;
    job.seq    = seq_r;
    job.data   = word.payload_byte;
    job.last   = word.final_byte;
    job.check  = check_sum;
  end

  always_comb begin
    seq_nxt    = seq_r;
    inside_nxt = inside_r;
    check_nxt  = check_r;
    if (accept && word.command) begin
      seq_nxt = !seq_r;
    end
    if (push) begin
      inside_nxt = !word.final_byte;
      check_nxt  = word.final_byte ? 8'd0 : check_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r    <= 1'b0;
      inside_r <= 1'b0;
      check_r  <= 8'd0;
    end else begin
      seq_r    <= seq_nxt;
      inside_r <= inside_nxt;
      check_r  <= check_nxt;
    end
  end

endmodule

FILE: rtl/core/ifbs_queue.sv
`timescale 1ns / 1ps

module ifbs_queue
  import ifbs_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output job_t head_job,
  output logic empty,
  output logic full
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    if (p == PTR_W'(DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign empty    = (count_r == '0);
  assign full     = (count_r == CNT_W'(DEPTH));
  assign head_job = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

FILE: rtl/core/ifbs_back.sv
`timescale 1ns / 1ps

module ifbs_back
  import ifbs_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg,
  input  logic      have_job,
  input  job_t      job,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  typedef enum logic [9:0] {
    ST_IDLE  = 10'b00_0000_0001,
    ST_FLAG  = 10'b00_0000_0010,
    ST_ADDR  = 10'b00_0000_0100,
    ST_CTRL  = 10'b00_0000_1000,
    ST_BCC1  = 10'b00_0001_0000,
    ST_DATA  = 10'b00_0010_0000,
    ST_DATA2 = 10'b00_0100_0000,
    ST_CHK   = 10'b00_1000_0000,
    ST_CHK2  = 10'b01_0000_0000,
    ST_CLOSE = 10'b10_0000_0000
  } step_t;

  step_t      step_r, step_nxt, cur_step, after_data;
  logic       out_valid_r, out_valid_nxt;
  out_word_t  out_word_r, out_word_nxt;
  logic       advance, emit, done;
  logic [7:0] ctrl, line_byte;
  logic       data_flag, data_special, chk_flag, chk_special;

  assign advance = !out_valid_r || !out_stall;
  assign emit    = advance && have_job;
  assign pop     = emit && done;

  assign ctrl         = job.seq ? cfg.control_seq_one : cfg.control_seq_zero;
  assign data_flag    = (job.data == cfg.flag_byte);
  assign data_special = data_flag || (job.data == cfg.escape_byte);
  assign chk_flag     = (job.check == cfg.flag_byte);
  assign chk_special  = chk_flag || (job.check == cfg.escape_byte);
  assign after_data   = job.last ? ST_CHK : ST_IDLE;
  assign cur_step     = (step_r == ST_IDLE) ? (job.header ? ST_FLAG : ST_DATA) : step_r;

  always_comb begin
    line_byte = cfg.flag_byte;
    done      = 1'b0;
    step_nxt  = ST_IDLE;
    unique case (cur_step)
      ST_FLAG: begin
        line_byte = cfg.flag_byte;
        step_nxt  = ST_ADDR;
      end
      ST_ADDR: begin
        line_byte = cfg.address_byte;
        step_nxt  = ST_CTRL;
      end
      ST_CTRL: begin
        line_byte = ctrl;
        step_nxt  = ST_BCC1;
      end
      ST_BCC1: begin
        line_byte = cfg.address_byte ^ ctrl;
        step_nxt  = ST_DATA;
      end
      ST_DATA: begin
        if (data_special) begin
          line_byte = cfg.escape_byte;
          step_nxt  = ST_DATA2;
        end else begin
          line_byte = job.data;
          step_nxt  = after_data;
          done      = !job.last;
        end
      end
      ST_DATA2: begin
        line_byte = data_flag ? cfg.flag_escaped : cfg.escape_escaped;
        step_nxt  = after_data;
        done      = !job.last;
      end
      ST_CHK: begin
        if (chk_special) begin
          line_byte = cfg.escape_byte;
          step_nxt  = ST_CHK2;
        end else begin
          line_byte = job.check;
          step_nxt  = ST_CLOSE;
        end
      end
      ST_CHK2: begin
        line_byte = chk_flag ? cfg.flag_escaped : cfg.escape_escaped;
        step_nxt  = ST_CLOSE;
      end
      ST_CLOSE: begin
        line_byte = cfg.flag_byte;
        step_nxt  = ST_IDLE;
        done      = 1'b1;
      end
      default: begin
        line_byte = cfg.flag_byte;
        step_nxt  = ST_IDLE;
        done      = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    if (advance) begin
      out_valid_nxt          = have_job;
      out_word_nxt.line_byte = line_byte;
      out_word_nxt.frame_end = (cur_step == ST_CLOSE);
      out_word_nxt.run_last  = done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r      <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (emit) begin
        step_r <= step_nxt;
      end
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule
